// File: rtl/core/group_reverse_stream_core_assert.svh
// assertion macros used by the group reverse stream checker
`ifndef GROUP_REVERSE_STREAM_CORE_ASSERT_SVH
`define GROUP_REVERSE_STREAM_CORE_ASSERT_SVH

// property checked from the cycle after pre, also while reset is high
`define GRS_ASSERT_AFTER(lbl, pre, post) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("group reverse stream check failed");

// property checked from the cycle after pre, out of reset only
`define GRS_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("group reverse stream check failed");

// property checked in the same cycle, out of reset only
`define GRS_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("group reverse stream check failed");

`endif

// File: rtl/core/grs_pkg.sv
// shared types and constants of the group reverse stream core
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

   localparam int MAX_GROUP_DEFAULT = 16;
   localparam int GSIZE_W = 5;
   localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd1;
   // wide enough for the largest supported group
   localparam int DESC_CNT_W = 7;

   typedef struct packed {
      logic signed [31:0] value;
      logic               end_of_list;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic               last_of_run;
      logic               last_of_list;
   } rsp_type;

   typedef struct packed {
      logic                  bank;
      logic [DESC_CNT_W-1:0] count;
      logic                  last;
   } desc_type;

endpackage

`default_nettype wire

// File: rtl/core/grs_front.sv
// front end: takes requests, fills the active bank and closes groups
`timescale 1ns / 1ps
`default_nettype none

module grs_front
   import grs_pkg::*;
#(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT,
   localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [GSIZE_W-1:0] csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               wr_en,
   output logic [AW:0]        wr_addr,
   output logic [31:0]        wr_data,
   output logic               q_valid,
   input  logic               q_ready,
   output desc_type           q_data,
   input  logic               bank_free,
   input  logic               bank_free_id
);

   localparam int CW = $clog2(MAX_GROUP + 1);
   localparam int KW = (CW > GSIZE_W) ? CW : GSIZE_W;
   localparam logic [KW-1:0] MAX_K = KW'(MAX_GROUP);

   logic [GSIZE_W-1:0] gsize_ff, gsize_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic               bank_ff, bank_in;
   logic [1:0]         busy_ff, busy_in;
   logic [KW-1:0]      gsize_ext;
   logic [KW-1:0]      k_eff;
   logic [CW-1:0]      fill_next;
   logic               accept;
   logic               flush;

   // sizes above MAX_GROUP clamp to it, zero behaves as one
   always_comb begin
      gsize_ext = KW'(gsize_ff);
      priority if (gsize_ext > MAX_K) begin
         k_eff = MAX_K;
      end else if (gsize_ext == '0) begin
         k_eff = KW'(1);
      end else begin
         k_eff = gsize_ext;
      end
   end

   assign req_ready = !busy_ff[bank_ff] && q_ready;
   assign accept    = req_valid && req_ready;
   // a group always closes before the bank overflows
   assign fill_next = fill_ff + CW'(1);
   assign flush     = accept && ((KW'(fill_next) >= k_eff) || req_data.end_of_list);

   assign wr_en   = accept;
   assign wr_addr = {bank_ff, fill_ff[AW-1:0]};
   assign wr_data = req_data.value;

   assign q_valid      = flush;
   assign q_data.bank  = bank_ff;
   assign q_data.count = DESC_CNT_W'(fill_next);
   assign q_data.last  = req_data.end_of_list;

   always_comb begin
      gsize_in = csr_we ? csr_wdata : gsize_ff;
      fill_in  = fill_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      if (bank_free) begin
         busy_in[bank_free_id] = 1'b0;
      end
      if (flush) begin
         busy_in[bank_ff] = 1'b1;
         bank_in          = ~bank_ff;
         fill_in          = '0;
      end else if (accept) begin
         fill_in = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gsize_ff <= GSIZE_RESET;
         fill_ff  <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         gsize_ff <= gsize_in;
         fill_ff  <= fill_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/grs_queue.sv
// two-entry queue of closed-group descriptors between front and back
`timescale 1ns / 1ps
`default_nettype none

module grs_queue
   import grs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  desc_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output desc_type pop_data
);

   desc_type   ent_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = ent_ff[rptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/grs_buf.sv
// two-bank group buffer, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module grs_buf
   import grs_pkg::*;
#(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT,
   localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [AW:0] wr_addr,
   input  logic [31:0] wr_data,
   input  logic        rd_en,
   input  logic [AW:0] rd_addr,
   output logic [31:0] rd_data
);

   localparam int DEPTH = 2 ** (AW + 1);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/grs_back.sv
// back end: drains a closed group newest first into the response register
`timescale 1ns / 1ps
`default_nettype none

module grs_back
   import grs_pkg::*;
#(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT,
   localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  desc_type    q_data,
   output logic        rd_en,
   output logic [AW:0] rd_addr,
   input  logic [31:0] rd_data,
   output logic        bank_free,
   output logic        bank_free_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   logic          act_ff, act_in;
   logic          bank_ff, bank_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          last_ff, last_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_lor_ff, s2_lor_in;
   logic          s2_lol_ff, s2_lol_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff, out_data_in;
   logic          out_take;
   logic          s2_move;
   logic          issue;
   logic          fin;
   logic          pop;

   assign out_take = !out_valid_ff || rsp_ready;
   assign s2_move  = s2_valid_ff && out_take;
   assign issue    = act_ff && (!s2_valid_ff || s2_move);
   assign fin      = issue && (idx_ff == '0);
   // next descriptor is taken as the last read of the current one goes out
   assign q_ready  = !act_ff || fin;
   assign pop      = q_valid && q_ready;

   assign rd_en        = issue;
   assign rd_addr      = {bank_ff, idx_ff};
   assign bank_free    = fin;
   assign bank_free_id = bank_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      act_in       = act_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      s2_valid_in  = s2_valid_ff;
      s2_lor_in    = s2_lor_ff;
      s2_lol_in    = s2_lol_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (pop) begin
         act_in  = 1'b1;
         bank_in = q_data.bank;
         idx_in  = AW'(q_data.count - DESC_CNT_W'(1));
         last_in = q_data.last;
      end else if (fin) begin
         act_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff - AW'(1);
      end

      if (issue) begin
         s2_valid_in = 1'b1;
         s2_lor_in   = (idx_ff == '0);
         s2_lol_in   = (idx_ff == '0) && last_ff;
      end else if (s2_move) begin
         s2_valid_in = 1'b0;
      end

      if (s2_move) begin
         out_valid_in             = 1'b1;
         out_data_in.value_out    = rd_data;
         out_data_in.last_of_run  = s2_lor_ff;
         out_data_in.last_of_list = s2_lol_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff     <= bank_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      s2_lor_ff   <= s2_lor_in;
      s2_lol_ff   <= s2_lol_in;
      out_data_ff <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/group_reverse_stream_core.sv
// top level of the group reverse stream core
//
// Requests (req_valid/req_ready, req_data) carry one signed 32-bit value and an
// end_of_list flag. Values gather into groups of csr group size (0 or 1 passes
// each value through, sizes above MAX_GROUP act as MAX_GROUP); a full group, or
// whatever is held when end_of_list arrives, leaves on the response channel
// (rsp_valid/rsp_ready, rsp_data) newest first. last_of_run marks the final
// value of each group, last_of_list the final value of the list.
// Throughput: one request per cycle while a buffer bank is free, one response
// per cycle while rsp_ready is high; two banks let one group drain while the
// next fills. The first response of a group follows the request that closes
// it through the descriptor queue, the back end's group registers, the buffer
// read register and the output register.
// Reset clears the group size to 1 and empties banks, queue and output.
// The user must write the group size through csr_we/csr_wdata only while idle; the block itself does not enforce it.
// When the receiver stalls, the response holds and the filling bank keeps
// taking requests until its group closes with the other bank still busy.
`timescale 1ns / 1ps
`default_nettype none

module group_reverse_stream_core
   import grs_pkg::*;
#(
   parameter int MAX_GROUP = MAX_GROUP_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [GSIZE_W-1:0] csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   logic        wr_en;
   logic [AW:0] wr_addr;
   logic [31:0] wr_data;
   logic        rd_en;
   logic [AW:0] rd_addr;
   logic [31:0] rd_data;
   logic        fq_valid;
   logic        fq_ready;
   desc_type    fq_data;
   logic        qb_valid;
   logic        qb_ready;
   desc_type    qb_data;
   logic        bank_free;
   logic        bank_free_id;

   grs_front #(.MAX_GROUP(MAX_GROUP)) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .q_valid      (fq_valid),
      .q_ready      (fq_ready),
      .q_data       (fq_data),
      .bank_free    (bank_free),
      .bank_free_id (bank_free_id)
   );

   grs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   grs_buf #(.MAX_GROUP(MAX_GROUP)) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   grs_back #(.MAX_GROUP(MAX_GROUP)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (qb_valid),
      .q_ready      (qb_ready),
      .q_data       (qb_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .bank_free    (bank_free),
      .bank_free_id (bank_free_id),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/core/grs_checker.sv
// port checker for the group reverse stream core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "group_reverse_stream_core_assert.svh"

module grs_checker
   import grs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // out of reset nothing is pending and requests are taken
   `GRS_ASSERT_AFTER(a_reset_idle, reset, !rsp_valid && req_ready)

   `GRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   `GRS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))

   // the end of the list always closes a group
   `GRS_ASSERT_NOW(a_list_ends_run, rsp_valid && rsp_data.last_of_list, rsp_data.last_of_run)

endmodule

bind group_reverse_stream_core grs_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
